// File: hw/rtl/fqp_pkg.sv
package fqp_pkg;

  localparam int unsigned CntW = 16;
  localparam logic [CntW-1:0] MaxReadLen = 16'hFFFF;

  // Result kinds
  localparam logic [2:0] KindId     = 3'd0;
  localparam logic [2:0] KindBase   = 3'd1;
  localparam logic [2:0] KindQual   = 3'd2;
  localparam logic [2:0] KindRecEnd = 3'd3;
  localparam logic [2:0] KindError  = 3'd4;
  localparam logic [2:0] KindDone   = 3'd5;

  // Error codes
  localparam logic [1:0] ErrBadStart = 2'd0;
  localparam logic [1:0] ErrEarlyEnd = 2'd1;
  localparam logic [1:0] ErrNoPlus   = 2'd2;

  // Characters
  localparam logic [7:0] CharAt    = 8'h40;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharN     = 8'h4E;
  localparam logic [7:0] CharA     = 8'h41;
  localparam logic [7:0] CharC     = 8'h43;
  localparam logic [7:0] CharG     = 8'h47;
  localparam logic [7:0] CharT     = 8'h54;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowZ  = 8'h7A;
  localparam logic [7:0] CaseDelta = 8'h20;

  localparam logic [7:0] BaseCodeA     = 8'd0;
  localparam logic [7:0] BaseCodeC     = 8'd1;
  localparam logic [7:0] BaseCodeG     = 8'd2;
  localparam logic [7:0] BaseCodeT     = 8'd3;
  localparam logic [7:0] BaseCodeOther = 8'd4;

  typedef enum logic [10:0] {
    PhStart     = 11'b000_0000_0001,
    PhSkipLine  = 11'b000_0000_0010,
    PhAfterSkip = 11'b000_0000_0100,
    PhBetween   = 11'b000_0000_1000,
    PhHeader    = 11'b000_0001_0000,
    PhHeaderEol = 11'b000_0010_0000,
    PhSeq       = 11'b000_0100_0000,
    PhSeqEol    = 11'b000_1000_0000,
    PhPlusLine  = 11'b001_0000_0000,
    PhQual      = 11'b010_0000_0000,
    PhError     = 11'b100_0000_0000
  } fqp_phase_e;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_input;
  } fqp_item_t;

  typedef struct packed {
    logic       emit;
    logic [2:0] kind;
    logic [7:0] value;
  } fqp_res_t;

  function automatic logic [7:0] base_code(input logic [7:0] c_in);
    logic [7:0] c;
    logic [7:0] code;
    c = c_in;
    if (c >= CharLowA && c <= CharLowZ) begin
      c = c - CaseDelta;
    end
    if (c == CharN) begin
      c = CharA;
    end
    unique case (c)
      CharA:   code = BaseCodeA;
      CharC:   code = BaseCodeC;
      CharG:   code = BaseCodeG;
      CharT:   code = BaseCodeT;
      default: code = BaseCodeOther;
    endcase
    return code;
  endfunction

endpackage

// File: hw/rtl/fqp_ifs.sv
interface fqp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_input;

  modport source (output valid, output byte_in, output end_of_input, input ready);
  modport sink (input valid, input byte_in, input end_of_input, output ready);
endinterface

interface fqp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink (input valid, input kind, input value, output ready);
endinterface

// File: hw/rtl/fastq_record_parser_top.sv
// Path: an input word is taken into the input register, and its result word
//   is then loaded into the result register whenever that register can load
//   (it is empty or its word is being taken at the output).
// Throughput: one input word per cycle while the output is not stalled; the
//   parse state machine decides each byte combinationally, so words never wait.
// Reset: rst_ni is asynchronous and active low; it clears both valid flags,
//   puts the parser at start of file, clears counts and the sticky error.
module fastq_record_parser_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  fqp_in_if.sink     in_i,
  fqp_out_if.source  out_o
);
  import fqp_pkg::*;

  // Hold one input word; it moves on whenever the result register can load.
  logic      item_valid;
  fqp_item_t item;
  logic      advance;
  fqp_res_t  res;

  fqp_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  // Decide the held byte: advance the parse phase and counts only when
  // the word actually moves on, so a stalled output leaves state untouched.
  fqp_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (item_valid && advance),
    .item_i (item),
    .res_o  (res)
  );

  // Capture the result word; a byte that yields nothing leaves it empty.
  fqp_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .res_i        (res),
    .advance_o    (advance),
    .out_o        (out_o)
  );

endmodule

// File: hw/rtl/fqp_in_reg.sv
module fqp_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  fqp_in_if.sink            in_i,
  input  logic              advance_i,
  output logic              item_valid_o,
  output fqp_pkg::fqp_item_t item_o
);
  import fqp_pkg::*;

  logic      valid_q, valid_d;
  fqp_item_t item_q, item_d;
  logic      take;

  // Refill when empty or whenever the held word moves on this cycle.
  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (in_i.ready) begin
      valid_d = in_i.valid;
    end
    if (take) begin
      item_d.byte_in      = in_i.byte_in;
      item_d.end_of_input = in_i.end_of_input;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// File: hw/rtl/fqp_parse.sv
module fqp_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  fqp_pkg::fqp_item_t item_i,
  output fqp_pkg::fqp_res_t  res_o
);
  import fqp_pkg::*;

  fqp_phase_e      phase_q, phase_d;
  logic [1:0]      err_q, err_d;
  logic [CntW-1:0] bcnt_q, bcnt_d;
  logic [CntW-1:0] qcnt_q, qcnt_d;
  logic [7:0]      c;
  logic            eoi;
  logic            is_eol;
  logic [CntW-1:0] bcnt_inc;
  logic [CntW-1:0] qcnt_inc;

  assign c        = item_i.byte_in;
  assign eoi      = item_i.end_of_input;
  assign is_eol   = (c == CharLf) || (c == CharCr);
  assign bcnt_inc = (bcnt_q >= MaxReadLen) ? MaxReadLen : bcnt_q + 1'b1;
  assign qcnt_inc = (qcnt_q >= MaxReadLen) ? MaxReadLen : qcnt_q + 1'b1;

  always_comb begin
    phase_d = phase_q;
    err_d   = err_q;
    bcnt_d  = bcnt_q;
    qcnt_d  = qcnt_q;
    res_o   = '0;
    if (step_i) begin
      unique case (phase_q)
        PhStart, PhSkipLine, PhAfterSkip: begin
          if (eoi) begin
            phase_d = PhError;
            err_d   = ErrBadStart;
            res_o   = '{1'b1, KindError, {6'd0, ErrBadStart}};
          end else if (phase_q == PhSkipLine) begin
            if (c == CharLf) phase_d = PhAfterSkip;
          end else if (phase_q == PhAfterSkip && is_eol) begin
            phase_d = PhAfterSkip;
          end else if (c == CharAt) begin
            phase_d = PhHeader;
          end else if (phase_q == PhStart) begin
            phase_d = (c == CharLf) ? PhAfterSkip : PhSkipLine;
          end else begin
            phase_d = PhError;
            err_d   = ErrBadStart;
            res_o   = '{1'b1, KindError, {6'd0, ErrBadStart}};
          end
        end
        PhBetween: begin
          if (eoi) begin
            res_o = '{1'b1, KindDone, 8'd0};
          end else if (!is_eol) begin
            phase_d = PhHeader;
            if (c != CharAt) res_o = '{1'b1, KindId, c};
          end
        end
        PhHeader: begin
          if (eoi) begin
            phase_d = PhError;
            err_d   = ErrEarlyEnd;
            res_o   = '{1'b1, KindError, {6'd0, ErrEarlyEnd}};
          end else if (is_eol) begin
            phase_d = PhHeaderEol;
          end else if (c != CharAt) begin
            res_o = '{1'b1, KindId, c};
          end
        end
        PhHeaderEol, PhSeq: begin
          if (eoi) begin
            phase_d = PhError;
            err_d   = ErrEarlyEnd;
            res_o   = '{1'b1, KindError, {6'd0, ErrEarlyEnd}};
          end else if (is_eol) begin
            phase_d = (phase_q == PhSeq) ? PhSeqEol : PhHeaderEol;
          end else if (phase_q == PhHeaderEol && c == CharPlus) begin
            phase_d = PhPlusLine;
          end else begin
            phase_d = PhSeq;
            bcnt_d  = bcnt_inc;
            res_o   = '{1'b1, KindBase, base_code(c)};
          end
        end
        PhSeqEol: begin
          if (eoi) begin
            phase_d = PhError;
            err_d   = ErrEarlyEnd;
            res_o   = '{1'b1, KindError, {6'd0, ErrEarlyEnd}};
          end else if (c == CharPlus) begin
            phase_d = PhPlusLine;
          end else if (!is_eol) begin
            phase_d = PhError;
            err_d   = ErrNoPlus;
            res_o   = '{1'b1, KindError, {6'd0, ErrNoPlus}};
          end
        end
        PhPlusLine: begin
          if (eoi) begin
            phase_d = PhError;
            err_d   = ErrEarlyEnd;
            res_o   = '{1'b1, KindError, {6'd0, ErrEarlyEnd}};
          end else if (c == CharLf) begin
            phase_d = PhQual;
          end
        end
        PhQual: begin
          if (eoi || is_eol) begin
            // Close the record and report a count mismatch.
            phase_d = PhBetween;
            bcnt_d  = '0;
            qcnt_d  = '0;
            res_o   = '{1'b1, KindRecEnd, {7'd0, bcnt_q != qcnt_q}};
          end else begin
            qcnt_d = qcnt_inc;
            res_o  = '{1'b1, KindQual, c};
          end
        end
        default: begin
          // Hold the sticky error.
          phase_d = PhError;
          res_o   = '{1'b1, KindError, {6'd0, err_q}};
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart;
      err_q   <= ErrBadStart;
      bcnt_q  <= '0;
      qcnt_q  <= '0;
    end else begin
      phase_q <= phase_d;
      err_q   <= err_d;
      bcnt_q  <= bcnt_d;
      qcnt_q  <= qcnt_d;
    end
  end

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhError |=> phase_q == PhError && $stable(err_q))
    else $error("error phase left before reset");

  a_err_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && phase_q == PhError) |->
      (res_o.emit && res_o.kind == KindError && res_o.value == {6'd0, err_q}))
    else $error("sticky error not repeated");

  a_cnt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhBetween || phase_q == PhHeader) |-> (bcnt_q == '0 && qcnt_q == '0))
    else $error("counts not cleared between records");

endmodule

// File: hw/rtl/fqp_out_reg.sv
module fqp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  fqp_pkg::fqp_res_t res_i,
  output logic              advance_o,
  fqp_out_if.source         out_o
);
  import fqp_pkg::*;

  logic       valid_q, valid_d;
  logic [2:0] kind_q, kind_d;
  logic [7:0] value_q, value_d;

  // Advance when the result word is empty or being taken.
  assign advance_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    kind_d  = kind_q;
    value_d = value_q;
    if (advance_o) begin
      valid_d = item_valid_i && res_i.emit;
      kind_d  = res_i.kind;
      value_d = res_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    value_q <= value_d;
  end

  assign out_o.valid = valid_q;
  assign out_o.kind  = kind_q;
  assign out_o.value = value_q;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import fqp_pkg::*;

  localparam int Latency    = 2;      // input register plus result register
  localparam int RandWords  = 1900;   // words to send as random records
  localparam int LongHoldAt = 300;    // result word after which the sink holds off
  localparam int LongHold   = 120;    // cycles of that hold-off
  localparam int DirRows    = 27;
  localparam longint TimeLimitNs = 64'd1_000_000;

  localparam fqp_res_t NoTok = '0;

  // One row of the directed table: the word to send and, where it can be
  // read off directly, the token it must produce (typed = 1).
  typedef struct packed {
    logic [7:0] chr;
    logic       eoi;
    logic       typed;
    fqp_res_t   tok;
  } dir_row_t;

  logic clk;
  logic rst_n;

  fqp_in_if  in_if ();
  fqp_out_if out_if ();

  fastq_record_parser_top uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Parser state as this bench sees it
  fqp_phase_e  ph;
  logic [15:0] read_bases;
  logic [15:0] read_quals;
  logic [1:0]  sticky_err;

  fqp_res_t pending_tokens[$];   // tokens still owed by the block, oldest first

  bit idle_on;         // both sides draw random gaps while set
  bit valid_up;        // what this bench last drove on in_if.valid
  int next_gap;        // cycles the source waits before its next word
  int words_in;
  int words_out;
  int tokens_made;
  int records_sent;
  int errors;

  // Directed part: bad first line, extreme bytes, every base code, a length
  // mismatch, repeated stream ends, a record without '@', an empty sequence
  // and an unterminated last quality line.
  dir_row_t dir_rows [DirRows] = '{
    '{"x",    1'b0, 1'b1, NoTok},                      // bad first line: skip it
    '{CharLf, 1'b0, 1'b0, NoTok},
    '{CharCr, 1'b0, 1'b0, NoTok},                      // terminator after the skip
    '{CharAt, 1'b0, 1'b1, NoTok},
    '{CharAt, 1'b0, 1'b1, NoTok},                      // second '@' is dropped
    '{8'hFF,  1'b0, 1'b1, '{1'b1, KindId, 8'hFF}},
    '{8'h00,  1'b0, 1'b1, '{1'b1, KindId, 8'h00}},
    '{CharLf, 1'b0, 1'b0, NoTok},
    '{"a",    1'b0, 1'b0, NoTok},
    '{"n",    1'b0, 1'b0, NoTok},
    '{"c",    1'b0, 1'b0, NoTok},
    '{"G",    1'b0, 1'b0, NoTok},
    '{"t",    1'b0, 1'b0, NoTok},
    '{8'h7F,  1'b0, 1'b0, NoTok},
    '{CharLf, 1'b0, 1'b0, NoTok},
    '{CharPlus, 1'b0, 1'b0, NoTok},
    '{CharLf, 1'b0, 1'b0, NoTok},
    '{8'h21,  1'b0, 1'b0, NoTok},
    '{8'hFF,  1'b0, 1'b1, '{1'b1, KindQual, 8'hFF}},
    '{CharCr, 1'b0, 1'b0, NoTok},                      // 6 bases vs 2 qualities
    '{8'hA5,  1'b1, 1'b1, '{1'b1, KindDone, 8'h00}},
    '{8'h5A,  1'b1, 1'b1, '{1'b1, KindDone, 8'h00}},   // done repeats
    '{"Q",    1'b0, 1'b0, NoTok},                      // header without '@'
    '{CharLf, 1'b0, 1'b0, NoTok},
    '{CharPlus, 1'b0, 1'b0, NoTok},                    // empty sequence
    '{CharLf, 1'b0, 1'b0, NoTok},
    '{8'hC3,  1'b1, 1'b1, '{1'b1, KindRecEnd, 8'h00}}  // end closes the record
  };

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------

  function automatic fqp_res_t token(input logic [2:0] kind, input logic [7:0] value);
    fqp_res_t t;
    t.emit  = 1'b1;
    t.kind  = kind;
    t.value = value;
    return t;
  endfunction

  function automatic logic is_eol(input logic [7:0] c);
    return (c == CharLf) || (c == CharCr);
  endfunction

  // Saturate at the read length limit
  function automatic logic [15:0] bump(input logic [15:0] n);
    return (n == MaxReadLen) ? n : n + 16'd1;
  endfunction

  function automatic logic [7:0] code_of_base(input logic [7:0] c_raw);
    logic [7:0] c;
    c = (c_raw >= "a" && c_raw <= "z") ? c_raw - 8'h20 : c_raw;
    case (c)
      "A", "N": return BaseCodeA;
      "C":      return BaseCodeC;
      "G":      return BaseCodeG;
      "T":      return BaseCodeT;
      default:  return BaseCodeOther;
    endcase
  endfunction

  // Enter the sticky error state and report the code
  function automatic fqp_res_t go_error(input logic [1:0] code);
    ph = PhError;
    sticky_err = code;
    return token(KindError, {6'd0, code});
  endfunction

  function automatic fqp_res_t take_base(input logic [7:0] c);
    ph = PhSeq;
    read_bases = bump(read_bases);
    return token(KindBase, code_of_base(c));
  endfunction

  // Advance the parser by one word; return the token it produces, if any
  function automatic fqp_res_t parse_fastq_byte(input logic [7:0] c, input logic eoi);
    fqp_res_t t;
    logic     mism;
    t = NoTok;
    case (ph)
      PhStart: begin
        if (eoi) begin
          t = go_error(ErrBadStart);
        end else if (c == CharAt) begin
          ph = PhHeader;
        end else begin
          ph = (c == CharLf) ? PhAfterSkip : PhSkipLine;
        end
      end
      PhSkipLine: begin
        if (eoi) t = go_error(ErrBadStart);
        else if (c == CharLf) ph = PhAfterSkip;
      end
      PhAfterSkip: begin
        if (eoi) begin
          t = go_error(ErrBadStart);
        end else if (c == CharAt) begin
          ph = PhHeader;
        end else if (!is_eol(c)) begin
          t = go_error(ErrBadStart);
        end
      end
      PhBetween: begin
        if (eoi) begin
          t = token(KindDone, 8'h00);
        end else if (!is_eol(c)) begin
          ph = PhHeader;
          if (c != CharAt) t = token(KindId, c);
        end
      end
      PhHeader: begin
        if (eoi) t = go_error(ErrEarlyEnd);
        else if (is_eol(c)) ph = PhHeaderEol;
        else if (c != CharAt) t = token(KindId, c);
      end
      PhHeaderEol: begin
        if (eoi) t = go_error(ErrEarlyEnd);
        else if (c == CharPlus) ph = PhPlusLine;
        else if (!is_eol(c)) t = take_base(c);
      end
      PhSeq: begin
        if (eoi) t = go_error(ErrEarlyEnd);
        else if (is_eol(c)) ph = PhSeqEol;
        else t = take_base(c);
      end
      PhSeqEol: begin
        if (eoi) t = go_error(ErrEarlyEnd);
        else if (c == CharPlus) ph = PhPlusLine;
        else if (!is_eol(c)) t = go_error(ErrNoPlus);
      end
      PhPlusLine: begin
        if (eoi) t = go_error(ErrEarlyEnd);
        else if (c == CharLf) ph = PhQual;
      end
      PhQual: begin
        if (eoi || is_eol(c)) begin
          mism = (read_bases != read_quals);
          read_bases = '0;
          read_quals = '0;
          ph = PhBetween;
          t = token(KindRecEnd, {7'd0, mism});
        end else begin
          read_quals = bump(read_quals);
          t = token(KindQual, c);
        end
      end
      default: begin
        ph = PhError;
        t = token(KindError, {6'd0, sticky_err});
      end
    endcase
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Source side
  // ---------------------------------------------------------------------------

  // Offer one word, hold it until taken, then predict its token. Lower valid
  // at the accepting edge only when a gap follows, so valid is never dropped
  // and raised in the same step.
  task automatic send_word(input logic [7:0] c, input logic eoi,
                           input logic typed, input fqp_res_t typed_tok);
    fqp_res_t t;
    repeat (next_gap) @(posedge clk);
    in_if.valid        <= 1'b1;
    in_if.byte_in      <= c;
    in_if.end_of_input <= eoi;
    valid_up = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    t = parse_fastq_byte(c, eoi);
    if (typed) t = typed_tok;
    if (t.emit) begin
      pending_tokens.push_back(t);
      tokens_made++;
    end
    words_in++;
    next_gap = idle_on ? $urandom_range(0, 4) : 0;
    if (next_gap != 0) begin
      in_if.valid <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  task automatic send_text(input logic [7:0] c);
    send_word(c, 1'b0, 1'b0, NoTok);
  endtask

  // End of input; the byte lane carries junk the block must ignore
  task automatic send_end();
    send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0, NoTok);
  endtask

  // Pause the source until every owed token has come back
  task automatic wait_drained();
    if (valid_up) begin
      in_if.valid <= 1'b0;
      valid_up = 1'b0;
    end
    do @(posedge clk); while (pending_tokens.size() != 0);
  endtask

  // Any byte except line terminators, optionally except '+' too
  function automatic logic [7:0] rand_text(input bit no_plus);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (is_eol(c) || (no_plus && c == CharPlus));
    return c;
  endfunction

  function automatic logic [7:0] rand_base_char();
    if ($urandom_range(0, 7) == 0) return rand_text(1'b1);
    case ($urandom_range(0, 9))
      0: return "A";
      1: return "C";
      2: return "G";
      3: return "T";
      4: return "N";
      5: return "a";
      6: return "c";
      7: return "g";
      8: return "t";
      default: return "n";
    endcase
  endfunction

  task automatic send_eol();
    case ($urandom_range(0, 3))
      0: begin send_text(CharCr); send_text(CharLf); end
      1: begin send_text(CharLf); send_text(CharLf); end
      default: send_text(CharLf);
    endcase
  endtask

  // One well-formed record with random content; lengths disagree now and then
  task automatic send_record();
    int seq_len;
    int qual_len;
    idle_on = ($urandom_range(0, 7) != 0);
    // Fill the gap between records: blank lines or a stream end
    case ($urandom_range(0, 9))
      0: send_end();
      1: begin send_text(CharCr); send_text(CharLf); end
      2: send_text(CharLf);
      default: ;
    endcase
    if ($urandom_range(0, 9) != 0) send_text(CharAt);
    repeat ($urandom_range(1, 8))
      send_text(($urandom_range(0, 7) == 0) ? CharAt : rand_text(1'b0));
    send_eol();
    seq_len = $urandom_range(0, 24);
    repeat (seq_len) send_text(rand_base_char());
    send_eol();
    send_text(CharPlus);
    repeat ($urandom_range(0, 3)) send_text(rand_text(1'b0));
    send_text(CharLf);
    qual_len = ($urandom_range(0, 3) != 0) ? seq_len : $urandom_range(0, 24);
    repeat (qual_len)
      send_text(($urandom_range(0, 7) == 0) ? rand_text(1'b0)
                                            : 8'($urandom_range(8'h21, 8'h7E)));
    case ($urandom_range(0, 9))
      0: send_end();                         // last line unterminated
      1: send_text(CharCr);
      2: begin send_text(CharCr); send_text(CharLf); end
      default: send_text(CharLf);
    endcase
    records_sent++;
  endtask

  // Break the last record so the block drops into its sticky error, then
  // keep feeding words to see the error repeated
  task automatic send_broken_tail();
    idle_on = 1'b1;
    send_text(CharAt);
    send_text("E");
    case ($urandom_range(0, 3))
      0: send_end();                                                    // inside header
      1: begin send_eol(); send_text("A"); send_text(CharLf); send_text("X"); end // no plus
      2: begin send_eol(); send_text("A"); send_end(); end              // inside sequence
      default: begin
        send_eol(); send_text("A"); send_eol(); send_text(CharPlus); send_end();
      end
    endcase
    repeat (6) send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'b0, NoTok);
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset, initial drive
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    in_if.valid        = 1'b0;
    in_if.byte_in      = 8'h00;
    in_if.end_of_input = 1'b0;
    out_if.ready       = 1'b0;
    ph            = PhStart;
    read_bases    = '0;
    read_quals    = '0;
    sticky_err    = ErrBadStart;
    idle_on       = 1'b1;
    valid_up      = 1'b0;
    next_gap      = 0;
    words_in      = 0;
    words_out     = 0;
    tokens_made   = 0;
    records_sent  = 0;
    errors        = 0;
  end

  // ---------------------------------------------------------------------------
  // Sink side: check every result word against the oldest owed token
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    fqp_res_t want;
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    out_if.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        words_out++;
        if (pending_tokens.size() == 0) begin
          $display("%0t: unexpected token, expected none, actual kind %0d value 0x%02h",
                   $time, out_if.kind, out_if.value);
          errors++;
        end else begin
          want = pending_tokens.pop_front();
          if (out_if.kind !== want.kind) begin
            $display("%0t: kind mismatch, expected %0d, actual %0d",
                     $time, want.kind, out_if.kind);
            errors++;
          end
          if (out_if.value !== want.value) begin
            $display("%0t: value mismatch (kind %0d), expected 0x%02h, actual 0x%02h",
                     $time, want.kind, want.value, out_if.value);
            errors++;
          end
        end
        // Stall after this word; once, hold off long enough to back the
        // block up into its input while the source keeps offering
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (words_out == LongHoldAt) gap = LongHold;
        if (gap != 0) begin
          out_if.ready <= 1'b0;
          repeat (gap) @(posedge clk);
          out_if.ready <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int base_words;
    int i;
    wait (rst_n === 1'b1);
    @(posedge clk);
    idle_on = 1'b1;
    for (i = 0; i < DirRows; i++)
      send_word(dir_rows[i].chr, dir_rows[i].eoi, dir_rows[i].typed, dir_rows[i].tok);
    // Hold the source until the directed tokens are all back
    wait_drained();
    base_words = words_in;
    while (words_in - base_words < RandWords) send_record();
    wait_drained();
    send_broken_tail();
    wait_drained();
    // Let any stray word surface before judging
    repeat (Latency * 10) @(posedge clk);
    $display("Sent %0d words: a directed table, %0d random records and a broken tail",
             words_in, records_sent);
    $display("Checked %0d of %0d predicted tokens, ending in the sticky error; %0d mismatches",
             words_out, tokens_made, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeLimitNs);
    $display("%0t: timeout, %0d tokens still owed", $time, pending_tokens.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/fqp_pkg.sv
hw/rtl/fqp_ifs.sv
hw/rtl/fqp_in_reg.sv
hw/rtl/fqp_parse.sv
hw/rtl/fqp_out_reg.sv
hw/rtl/fastq_record_parser_top.sv
tb/testbench.sv
